// File: sv/color_string_parser_assert.svh
// Assertion macros for the color string parser checker.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef COLOR_STRING_PARSER_ASSERT_SVH
`define COLOR_STRING_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("color string parser check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("color string parser check failed");

`define CSP_ASSERT_TWO(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("color string parser check failed");

`endif

// File: sv/csp_pkg.sv
// Shared types and constants for the color string parser.
// No dependencies; used by every module of the block but csp_fifo.
package csp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic       used_default;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_item_t;

    // Character class computed by the front end and queued for the parser.
    typedef struct packed {
        logic       is_zero;
        logic       last;
        logic       is_space;
        logic       is_digit;
        logic       is_hash;
        logic       is_sign;
        logic       is_minus;
        logic       hex_ok;
        logic [3:0] nib;
    } char_class_t;

    localparam int IN_QUEUE_DEPTH  = 2;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic [31:0] DEFAULT_COLOR_RESET = 32'h0000_00FF;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam logic [3:0] HEX_SHORT = 4'd6;
    localparam logic [3:0] HEX_LONG  = 4'd8;
    localparam logic [3:0] HEX_SAT   = 4'd9;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHAN_MAX     = 8'hFF;

endpackage

// File: sv/csp_fifo.sv
// Small first-in first-out queue built from registers.
// Generic; uses no package items.
module csp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/csp_front.sv
// Front end: classifies one incoming character for the parser.
// Depends on csp_pkg for the request and class types.
module csp_front (
    input  csp_pkg::char_item_t  char_item,
    output csp_pkg::char_class_t cls
);

    logic [7:0] c;
    logic       upper_hex, lower_hex;

    assign c         = char_item.char_code;
    assign upper_hex = (c >= csp_pkg::CHAR_UA) && (c <= csp_pkg::CHAR_UF);
    assign lower_hex = (c >= csp_pkg::CHAR_LA) && (c <= csp_pkg::CHAR_LF);

    always_comb
    begin
        cls.is_zero  = (c == 8'd0);
        cls.last     = char_item.last_char;
        cls.is_space = (c == csp_pkg::CHAR_SPACE)
                    || ((c >= csp_pkg::CHAR_TAB) && (c <= csp_pkg::CHAR_CR));
        cls.is_digit = (c >= csp_pkg::CHAR_0) && (c <= csp_pkg::CHAR_9);
        cls.is_hash  = (c == csp_pkg::CHAR_HASH);
        cls.is_sign  = (c == csp_pkg::CHAR_PLUS) || (c == csp_pkg::CHAR_MINUS);
        cls.is_minus = (c == csp_pkg::CHAR_MINUS);
        cls.hex_ok   = cls.is_digit || upper_hex || lower_hex;
        // Letters a-f and A-F share their low nibble pattern; adding nine gives their value.
        if (cls.is_digit)
        begin
            cls.nib = c[3:0];
        end
        else
        begin
            cls.nib = c[3:0] + 4'd9;
        end
    end

endmodule

// File: sv/csp_back.sv
// Back end: parse state machine that consumes classified characters and builds colors.
// Depends on csp_pkg for the class and result types and the constants.
module csp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csp_pkg::char_class_t cls,
    input  logic                 cls_valid,
    output logic                 cls_take,
    input  logic                 res_full,
    output logic                 res_push,
    output csp_pkg::color_item_t res,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_HEX   = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_SIGN  = 3'd3;
    localparam logic [2:0] PH_DIGIT = 3'd4;
    localparam logic [2:0] PH_OK    = 3'd5;
    localparam logic [2:0] PH_FAIL  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hex_cnt_reg, hex_cnt_next;
    logic [31:0] color_reg, color_next;
    logic [15:0] dec_reg, dec_next;
    logic [1:0]  idx_reg, idx_next;
    logic        neg_reg, neg_next;
    logic        ended_reg;
    logic [31:0] default_color_reg;

    logic        end_item;
    logic        ok;
    logic [31:0] col;
    logic        do_wait;

    // Negate modulo 65536 when a minus sign was seen, then clamp to one byte.
    function automatic logic [7:0] sat_byte(input logic [15:0] d, input logic n);
        logic [15:0] v;
        v = n ? (16'd0 - d) : d;
        return (v > 16'(csp_pkg::CHAN_MAX)) ? csp_pkg::CHAN_MAX : v[7:0];
    endfunction

    function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [1:0] idx,
                                               input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        case (idx)
            2'd0:    r[31:24] = acc[31:24] | b;
            2'd1:    r[23:16] = acc[23:16] | b;
            2'd2:    r[15:8]  = acc[15:8] | b;
            default: r[7:0]   = acc[7:0] | b;
        endcase
        return r;
    endfunction

    assign end_item = cls.is_zero || cls.last;
    assign cls_take = cls_valid && !res_full;
    assign res_push = cls_take && end_item;

    always_comb
    begin
        // A new string starts from cleared parse state.
        if (ended_reg)
        begin
            phase_next   = PH_LEAD;
            hex_cnt_next = '0;
            color_next   = '0;
            dec_next     = '0;
            idx_next     = '0;
            neg_next     = 1'b0;
        end
        else
        begin
            phase_next   = phase_reg;
            hex_cnt_next = hex_cnt_reg;
            color_next   = color_reg;
            dec_next     = dec_reg;
            idx_next     = idx_reg;
            neg_next     = neg_reg;
        end
        do_wait = 1'b0;

        if (!cls.is_zero)
        begin
            case (phase_next)
                PH_LEAD:
                begin
                    if (!cls.is_space)
                    begin
                        if (cls.is_hash)
                        begin
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            do_wait = 1'b1;
                        end
                    end
                end
                PH_HEX:
                begin
                    if (!cls.hex_ok)
                    begin
                        phase_next = ((hex_cnt_next == csp_pkg::HEX_SHORT)
                                   || (hex_cnt_next == csp_pkg::HEX_LONG)) ? PH_OK : PH_FAIL;
                    end
                    else
                    begin
                        if (hex_cnt_next < csp_pkg::HEX_LONG)
                        begin
                            color_next = {color_next[27:0], cls.nib};
                        end
                        if (hex_cnt_next < csp_pkg::HEX_SAT)
                        begin
                            hex_cnt_next = hex_cnt_next + 1'b1;
                        end
                    end
                end
                PH_WAIT:
                begin
                    do_wait = 1'b1;
                end
                PH_SIGN:
                begin
                    if (cls.is_digit)
                    begin
                        dec_next   = {12'd0, cls.nib};
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_DIGIT:
                begin
                    if (cls.is_digit)
                    begin
                        dec_next = (dec_next << 3) + (dec_next << 1) + {12'd0, cls.nib};
                    end
                    else
                    begin
                        color_next = merge_byte(color_next, idx_next,
                                                sat_byte(dec_next, neg_next));
                        phase_next = (idx_next == 2'd2) ? PH_OK : PH_WAIT;
                        idx_next   = idx_next + 1'b1;
                        dec_next   = '0;
                        neg_next   = 1'b0;
                        do_wait    = (phase_next == PH_WAIT);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_wait)
        begin
            if (cls.is_space)
            begin
                phase_next = PH_WAIT;
            end
            else if (cls.is_sign)
            begin
                neg_next   = cls.is_minus;
                phase_next = PH_SIGN;
            end
            else if (cls.is_digit)
            begin
                dec_next   = {12'd0, cls.nib};
                phase_next = PH_DIGIT;
            end
            else
            begin
                phase_next = PH_FAIL;
            end
        end

        // End of string: a number still being read is closed out here.
        ok  = 1'b0;
        col = default_color_reg;
        if (phase_next == PH_HEX)
        begin
            if (hex_cnt_next == csp_pkg::HEX_LONG)
            begin
                ok  = 1'b1;
                col = color_next;
            end
            else if (hex_cnt_next == csp_pkg::HEX_SHORT)
            begin
                ok  = 1'b1;
                col = {color_next[23:0], csp_pkg::ALPHA_OPAQUE};
            end
        end
        else
        begin
            if (end_item && (phase_next == PH_DIGIT))
            begin
                color_next = merge_byte(color_next, idx_next, sat_byte(dec_next, neg_next));
                phase_next = (idx_next == 2'd2) ? PH_OK : PH_WAIT;
                idx_next   = idx_next + 1'b1;
                dec_next   = '0;
                neg_next   = 1'b0;
            end
            if (phase_next == PH_OK)
            begin
                ok = 1'b1;
                if (hex_cnt_next == csp_pkg::HEX_SHORT)
                begin
                    col = {color_next[23:0], csp_pkg::ALPHA_OPAQUE};
                end
                else if (hex_cnt_next == csp_pkg::HEX_LONG)
                begin
                    col = color_next;
                end
                else
                begin
                    col = {color_next[31:8], csp_pkg::ALPHA_OPAQUE};
                end
            end
        end

        res.used_default = !ok;
        res.red          = col[31:24];
        res.green        = col[23:16];
        res.blue         = col[15:8];
        res.alpha        = col[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEAD;
            hex_cnt_reg       <= '0;
            color_reg         <= '0;
            dec_reg           <= '0;
            idx_reg           <= '0;
            neg_reg           <= 1'b0;
            ended_reg         <= 1'b0;
            default_color_reg <= csp_pkg::DEFAULT_COLOR_RESET;
        end
        else
        begin
            if (cls_take)
            begin
                phase_reg   <= phase_next;
                hex_cnt_reg <= hex_cnt_next;
                color_reg   <= color_next;
                dec_reg     <= dec_next;
                idx_reg     <= idx_next;
                neg_reg     <= neg_next;
                ended_reg   <= end_item;
            end
            if (cfg_we)
            begin
                default_color_reg <= cfg_data;
            end
        end
    end

endmodule

// File: sv/color_string_parser.sv
// Color string parser: takes one character per cycle unless a queue is full, and
// delivers one color per string, either "#" with six or eight hex digits or three
// decimal numbers, else the default color. A character may be pushed every cycle
// while full is low. The request ending a string is held in the input queue, and
// then the parser writes its color straight into the output queue. With no stall on
// the output side, empty drops once the color has passed both queues. The parser
// stops taking characters while the output queue is full. The depth of the two
// queues sets how long each side may stall before the other side sees full.
// Depends on csp_pkg, csp_front, csp_fifo and csp_back.
module color_string_parser #(
    parameter int IN_DEPTH  = csp_pkg::IN_QUEUE_DEPTH,
    parameter int OUT_DEPTH = csp_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  csp_pkg::char_item_t  char_item,
    input  logic                 pop,
    output logic                 empty,
    output csp_pkg::color_item_t color_item,
    input  logic                 default_color_we,
    input  logic [31:0]          default_color
);

    csp_pkg::char_class_t cls_in, cls_out;
    csp_pkg::color_item_t res;
    logic                 cls_empty;
    logic                 cls_take;
    logic                 res_full;
    logic                 res_push;

    csp_front u_front (
        .char_item (char_item),
        .cls       (cls_in)
    );

    csp_fifo #(
        .WIDTH ($bits(csp_pkg::char_class_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (cls_take),
        .rd_data (cls_out),
        .empty   (cls_empty)
    );

    csp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (cls_out),
        .cls_valid (!cls_empty),
        .cls_take  (cls_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .cfg_we    (default_color_we),
        .cfg_data  (default_color)
    );

    csp_fifo #(
        .WIDTH ($bits(csp_pkg::color_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (color_item),
        .empty   (empty)
    );

endmodule

// File: sv/csp_checker.sv
// Port-level checker for the color string parser, bound to the top level.
// Depends on csp_pkg and the macros in color_string_parser_assert.svh.
`include "color_string_parser_assert.svh"

module csp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input csp_pkg::char_item_t  char_item,
    input logic                 pop,
    input logic                 empty,
    input csp_pkg::color_item_t color_item
);

    // A waiting result that is not taken stays put.
    `CSP_ASSERT_NEXT(a_result_held, clk, rst_n, (!empty && !pop), (!empty && $stable(color_item)))

    // With nothing waiting on the output side the parser drains the input queue.
    `CSP_ASSERT_NEXT(a_full_drains, clk, rst_n, (full && empty), (!full))

    // A request that ends a string, accepted while the output queue is empty, must make it non-empty.
    `CSP_ASSERT_TWO(a_end_latency, clk, rst_n,
        (push && !full && empty && (char_item.last_char || (char_item.char_code == 8'd0))),
        (!empty))

endmodule

bind color_string_parser csp_checker u_csp_checker (.*);

// File: sim/tb_top.sv
// Testbench for color_string_parser: drives character strings through the queue ports
// and checks each color against a predictor of the parser kept in a scoreboard class.
// Depends on csp_pkg and the color_string_parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import csp_pkg::*;

    typedef bit [7:0] text_t[$];

    typedef enum int {
        P_LEAD, P_HEX, P_GAP, P_SIGN, P_DIGITS, P_DONE, P_BAD
    } parse_phase_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PER_PHASE = 170;

    // Predicts the color for every string and holds the colors still owed by the block.
    class color_scoreboard;
        bit [31:0]     fallback;
        parse_phase_t  phase;
        bit [3:0]      hex_cnt;
        bit [31:0]     col_acc;
        bit [15:0]     dec_acc;
        bit [1:0]      num_idx;
        bit            neg;
        bit            ended;
        color_item_t   expected_colors[$];
        int            errors;
        int            checked;

        function new();
            fallback = DEFAULT_COLOR_RESET;
            errors = 0;
            checked = 0;
            clear();
        endfunction

        function void clear();
            phase = P_LEAD;
            hex_cnt = 0;
            col_acc = 0;
            dec_acc = 0;
            num_idx = 0;
            neg = 0;
            ended = 0;
        endfunction

        function bit is_ws(bit [7:0] c);
            return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
        endfunction

        function bit is_dig(bit [7:0] c);
            return c >= CHAR_0 && c <= CHAR_9;
        endfunction

        // Returns 16 for a character that is not a hex digit.
        function int hex_val(bit [7:0] c);
            if (is_dig(c)) return c - CHAR_0;
            if (c >= CHAR_UA && c <= CHAR_UF) return c - CHAR_UA + 10;
            if (c >= CHAR_LA && c <= CHAR_LF) return c - CHAR_LA + 10;
            return 16;
        endfunction

        function void close_number();
            bit [15:0] v;
            v = dec_acc;
            if (neg) v = -v;
            if (v > CHAN_MAX) v = CHAN_MAX;
            col_acc |= {16'h0, v} << (24 - 8 * num_idx);
            num_idx++;
            dec_acc = 0;
            neg = 0;
            phase = (num_idx == 2'd3) ? P_DONE : P_GAP;
        endfunction

        function void open_number(bit [7:0] c);
            if (is_ws(c)) begin
                phase = P_GAP;
            end
            else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                neg = (c == CHAR_MINUS);
                phase = P_SIGN;
            end
            else if (is_dig(c)) begin
                dec_acc = c - CHAR_0;
                phase = P_DIGITS;
            end
            else begin
                phase = P_BAD;
            end
        endfunction

        function void take(bit [7:0] c);
            int h;
            case (phase)
                P_LEAD:
                    if (!is_ws(c)) begin
                        if (c == CHAR_HASH) phase = P_HEX;
                        else open_number(c);
                    end
                P_HEX: begin
                    h = hex_val(c);
                    if (h == 16) begin
                        phase = (hex_cnt == HEX_SHORT || hex_cnt == HEX_LONG) ? P_DONE : P_BAD;
                    end
                    else begin
                        if (hex_cnt < HEX_LONG) col_acc = {col_acc[27:0], 4'(h)};
                        if (hex_cnt < HEX_SAT) hex_cnt++;
                    end
                end
                P_GAP: open_number(c);
                P_SIGN:
                    if (is_dig(c)) begin
                        dec_acc = c - CHAR_0;
                        phase = P_DIGITS;
                    end
                    else begin
                        phase = P_BAD;
                    end
                P_DIGITS:
                    if (is_dig(c)) begin
                        dec_acc = dec_acc * 10 + (c - CHAR_0);
                    end
                    else begin
                        close_number();
                        if (phase == P_GAP) open_number(c);
                    end
                default: ;
            endcase
        endfunction

        function void note_char(char_item_t it);
            bit ok;
            bit [31:0] col;
            color_item_t want;
            if (ended) clear();
            if (it.char_code != 0) take(it.char_code);
            if (it.char_code != 0 && !it.last_char) return;
            ok = 0;
            col = 0;
            if (phase == P_HEX) begin
                if (hex_cnt == HEX_LONG) begin
                    ok = 1;
                    col = col_acc;
                end
                else if (hex_cnt == HEX_SHORT) begin
                    ok = 1;
                    col = {col_acc[23:0], ALPHA_OPAQUE};
                end
            end
            else begin
                if (phase == P_DIGITS) close_number();
                if (phase == P_DONE) begin
                    ok = 1;
                    if (hex_cnt == HEX_SHORT) col = {col_acc[23:0], ALPHA_OPAQUE};
                    else if (hex_cnt == HEX_LONG) col = col_acc;
                    else col = {col_acc[31:8], ALPHA_OPAQUE};
                end
            end
            if (!ok) col = fallback;
            want.used_default = !ok;
            want.red = col[31:24];
            want.green = col[23:16];
            want.blue = col[15:8];
            want.alpha = col[7:0];
            expected_colors.push_back(want);
            ended = 1;
        endfunction

        function void check_color(color_item_t got);
            color_item_t want;
            if (expected_colors.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("color %0h arrived with none outstanding", got);
                return;
            end
            want = expected_colors.pop_front();
            checked++;
            if (got.used_default !== want.used_default || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha) begin
                errors++;
                if (errors <= 10)
                    $display("color %0d: expected dflt=%b rgba=%h_%h_%h_%h, got dflt=%b rgba=%h_%h_%h_%h",
                             checked, want.used_default, want.red, want.green, want.blue,
                             want.alpha, got.used_default, got.red, got.green, got.blue,
                             got.alpha);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n;
    logic        push;
    logic        full;
    char_item_t  char_item;
    logic        pop;
    logic        empty;
    color_item_t color_item;
    logic        default_color_we;
    logic [31:0] default_color;

    color_scoreboard colors = new();
    int  cycles = 0;
    int  items_sent = 0;
    int  send_idle = 0;
    int  pop_stall = 0;
    bit [7:0] ws_pool[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    color_string_parser uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .char_item(char_item),
        .pop(pop),
        .empty(empty),
        .color_item(color_item),
        .default_color_we(default_color_we),
        .default_color(default_color)
    );

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= (pop_stall == 0) || ($urandom_range(99) >= pop_stall);

    always @(posedge clk)
        if (rst_n && pop && !empty) colors.check_color(color_item);

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_char(bit [7:0] c, bit last);
        char_item_t it;
        it.char_code = c;
        it.last_char = last;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        char_item <= it;
        do @(posedge clk); while (full);
        colors.note_char(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(text_t s, bit zero_end, bit zero_last);
        foreach (s[i]) send_char(s[i], !zero_end && i == s.size() - 1);
        if (zero_end || s.size() == 0) send_char(8'h00, zero_last);
    endtask

    task automatic wait_for_colors();
        push <= 0;
        while (colors.expected_colors.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_default(bit [31:0] v);
        default_color_we <= 1;
        default_color <= v;
        @(negedge clk);
        default_color_we <= 0;
        colors.fallback = v;
    endtask

    function automatic text_t to_text(string str);
        text_t s;
        for (int i = 0; i < str.len(); i++) s.push_back(str[i]);
        return s;
    endfunction

    function automatic bit [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'(CHAR_0 + v);
        return 8'(($urandom_range(1) ? CHAR_UA : CHAR_LA) + v - 10);
    endfunction

    function automatic text_t make_string();
        text_t s;
        int kind;
        int n;
        int sgn;
        kind = $urandom_range(9);
        if (kind == 9) begin
            repeat ($urandom_range(6)) s.push_back(8'($urandom_range(255, 1)));
            return s;
        end
        repeat ($urandom_range(2)) s.push_back(ws_pool[$urandom_range(5)]);
        if (kind < 4 || (kind == 8 && $urandom_range(1))) begin
            s.push_back(CHAR_HASH);
            if ($urandom_range(9) < 7) n = $urandom_range(1) ? 8 : 6;
            else n = $urandom_range(10);
            repeat (n) s.push_back(hex_char());
        end
        else begin
            for (int k = 0; k < 3; k++) begin
                sgn = $urandom_range(3);
                // A signed number may follow the previous one with no whitespace.
                if (k > 0 && (sgn < 2 || $urandom_range(1)))
                    repeat ($urandom_range(2, 1)) s.push_back(ws_pool[$urandom_range(5)]);
                if (sgn == 2) s.push_back(CHAR_PLUS);
                if (sgn == 3) s.push_back(CHAR_MINUS);
                n = ($urandom_range(6) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1);
                repeat (n) s.push_back(8'(CHAR_0 + $urandom_range(9)));
            end
        end
        if ($urandom_range(9) < 4)
            repeat ($urandom_range(3, 1)) s.push_back(8'($urandom_range(126, 32)));
        if (kind == 8 && s.size() > 0) begin
            if ($urandom_range(1)) begin
                n = $urandom_range(s.size() - 1);
                while (s.size() > n) void'(s.pop_back());
            end
            else begin
                s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255, 1));
            end
        end
        return s;
    endfunction

    int idle_send_pct[4] = '{0, 59, 0, 21};
    int idle_pop_pct[4]  = '{0, 0, 59, 21};

    initial begin
        bit [31:0] fallbacks[4];
        text_t s;
        fallbacks = '{DEFAULT_COLOR_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom};
        rst_n = 0;
        push = 0;
        char_item = '0;
        pop = 0;
        default_color_we = 0;
        default_color = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                wait_for_colors();
                write_default(fallbacks[ph]);
            end
            send_idle = idle_send_pct[ph];
            pop_stall = idle_pop_pct[ph];
            if (ph == 0) begin
                // Six hex digits, eight hex digits ended by a zero byte, signs glued
                // to numbers with wrap-around, and an empty string.
                send_text(to_text("#A1b2C3"), 0, 0);
                send_text(to_text("#0123abCD"), 1, 0);
                send_text(to_text("\t1-2+3"), 0, 0);
                send_text(to_text(""), 1, 1);
            end
            while (items_sent < (ph + 1) * RANDOM_PER_PHASE) begin
                s = make_string();
                send_text(s, $urandom_range(3) == 0, $urandom_range(1));
                if ($urandom_range(39) == 0) wait_for_colors();
            end
        end
        wait_for_colors();

        $display("Sent %0d characters and checked %0d colors under four handshake mixes.",
                 items_sent, colors.checked);
        $display("Fallback color covered reset, all-zero, all-one and a random value.");
        if (colors.errors == 0 && colors.expected_colors.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
